@@ hdl/frfcfs_pkg.sv @@
// Shared types and codes for the FR-FCFS bank scheduler.
package frfcfs_pkg;

    // Field widths fixed by the request format
    localparam int BANK_W = 4;
    localparam int CFG_W  = 7;
    localparam int CIDX_W = 3;

    // Item modes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_SCHED = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_ADDED   = 2'd0;
    localparam logic [1:0] STAT_REFUSED = 2'd1;
    localparam logic [1:0] STAT_GRANTED = 2'd2;
    localparam logic [1:0] STAT_NONE    = 2'd3;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_SPLIT    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_HIGH     = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_LOW      = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_RD_LIMIT = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_WR_LIMIT = 3'd4;

    // Configuration reset values
    localparam logic [CFG_W-1:0] HIGH_RST  = 7'd32;
    localparam logic [CFG_W-1:0] LOW_RST   = 7'd16;
    localparam logic [CFG_W-1:0] LIMIT_RST = 7'd64;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SWEEP
    } sched_state_t;

endpackage

@@ hdl/frfcfs_dram_bank_scheduler.sv @@
// FR-FCFS DRAM bank scheduler with write-drain watermarks, pools held in one RAM.
// Add, mode 3 or bad-bank items: result beat in the cycle after start, busy stays low.
// Schedule over n pending entries of the chosen pool (n <= POOL_ENTRIES): a scan pass
// and a compaction pass, each reading the entries in turn through the single RAM read
// port; busy through both passes, grant beat after the compaction pass, nothing-found beat after the scan pass alone.
// Reset empties the pools by clearing their counts, and clears locks and drain mode; results cannot be stalled.
module frfcfs_dram_bank_scheduler #(
    parameter int BANK_COUNT   = 16,
    parameter int POOL_ENTRIES = 64,
    parameter int ROW_BITS     = 16,
    parameter int TAG_BITS     = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         mode,
    input  logic [frfcfs_pkg::BANK_W-1:0]      bank,
    input  logic [ROW_BITS-1:0]                row,
    input  logic                               write_req,
    input  logic                               is_fill,
    input  logic [TAG_BITS-1:0]                tag,
    input  logic                               cfg_we,
    input  logic [frfcfs_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [frfcfs_pkg::CFG_W-1:0]       cfg_data,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [TAG_BITS-1:0]                granted_tag,
    output logic [ROW_BITS-1:0]                granted_row,
    output logic                               granted_write,
    output logic                               granted_fill,
    output logic                               row_hit
);

    localparam int IW    = $clog2(POOL_ENTRIES);
    localparam int PW    = $clog2(POOL_ENTRIES + 1);
    localparam int CW    = (PW > frfcfs_pkg::CFG_W) ? PW : frfcfs_pkg::CFG_W;
    localparam int AW    = IW + 1;
    localparam int EW    = frfcfs_pkg::BANK_W + 2 + TAG_BITS + ROW_BITS;
    localparam int LK_N  = (BANK_COUNT < 16) ? BANK_COUNT : 16;
    localparam int LKW   = (LK_N > 1) ? $clog2(LK_N) : 1;
    localparam int WR_B  = ROW_BITS + TAG_BITS;
    localparam int FL_B  = WR_B + 1;
    localparam int BK_B  = WR_B + 2;
    localparam logic [CW-1:0] POOL_CAP = CW'(POOL_ENTRIES);
    localparam logic [6:0]    BANK_LIM = 7'(BANK_COUNT);

    // Configuration registers
    logic                          split_reg;
    logic [frfcfs_pkg::CFG_W-1:0]  high_reg, low_reg, rlim_reg, wlim_reg;

    // Pool state
    logic [EW-1:0]   mem [2*POOL_ENTRIES];
    logic [EW-1:0]   rdata_reg;
    logic            rvalid_reg;
    logic [IW-1:0]   ridx_reg;
    logic [PW-1:0]   rp_reg, wp_reg;
    logic            drain_reg;
    logic            lk_vld_reg [2][LK_N];
    logic [ROW_BITS-1:0] lk_row_reg [2][LK_N];

    // Item context
    frfcfs_pkg::sched_state_t state_reg, state_next;
    logic                         sel_reg;
    logic [frfcfs_pkg::BANK_W-1:0] bank_reg;
    logic [ROW_BITS-1:0]          open_reg;
    logic                         fonly_reg;
    logic                         lkv_reg;
    logic [ROW_BITS-1:0]          lkr_reg;
    logic [PW-1:0]                n_reg, rd_cnt_reg;

    // Scan candidates
    logic          a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [IW-1:0] a_idx_reg, b_idx_reg, c_idx_reg, d_idx_reg, e_idx_reg;
    logic [ROW_BITS-1:0] c_row_reg, d_row_reg;

    // Grant context
    logic [IW-1:0]       gidx_reg;
    logic [ROW_BITS-1:0] grow_reg;
    logic                hit_reg, still_reg;
    logic [TAG_BITS-1:0] gtag_reg;
    logic                gwr_reg, gfill_reg;

    // Result registers
    logic                done_reg;
    logic [1:0]          status_reg;
    logic [TAG_BITS-1:0] otag_reg;
    logic [ROW_BITS-1:0] orow_reg;
    logic                owr_reg, ofill_reg, ohit_reg;

    logic accept, bank_ok, to_wr, full, drain_upd;
    logic [PW-1:0] add_cnt;
    logic [CW-1:0] lim_ext, lim_eff;
    logic [LKW-1:0] lk_in, lk_cur;
    logic mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic scan_end, sweep_end;
    logic have;
    logic [IW-1:0] dec_idx;
    logic [ROW_BITS-1:0] dec_row;
    logic dec_hit;
    logic e_bm, e_fill;
    logic [ROW_BITS-1:0] e_row;

    assign accept  = start && !busy;
    assign bank_ok = {3'b000, bank} < BANK_LIM;
    assign lk_in   = bank[LKW-1:0];
    assign lk_cur  = bank_reg[LKW-1:0];

    // Add path: pool choice and fullness
    always_comb
    begin
        to_wr   = split_reg && write_req;
        add_cnt = to_wr ? wp_reg : rp_reg;
        lim_ext = CW'(to_wr ? wlim_reg : rlim_reg);
        lim_eff = (lim_ext > POOL_CAP) ? POOL_CAP : lim_ext;
        full    = (CW'(add_cnt) >= lim_eff) || !bank_ok;
    end

    // Watermark update for the schedule about to start
    always_comb
    begin
        drain_upd = drain_reg;
        if (split_reg)
        begin
            if (!drain_reg && (CW'(wp_reg) >= CW'(high_reg)))
                drain_upd = 1'b1;
            else if (drain_reg && (CW'(wp_reg) < CW'(low_reg)))
                drain_upd = 1'b0;
        end
    end

    // Fields of the entry coming out of the RAM
    assign e_row  = rdata_reg[ROW_BITS-1:0];
    assign e_fill = rdata_reg[FL_B];
    assign e_bm   = rdata_reg[BK_B +: frfcfs_pkg::BANK_W] == bank_reg;

    // Row choice at the end of the scan
    always_comb
    begin
        have    = 1'b0;
        dec_idx = c_idx_reg;
        dec_row = c_row_reg;
        dec_hit = 1'b0;
        if (fonly_reg)
        begin
            have = d_reg;
            if (e_reg)
            begin
                dec_idx = e_idx_reg;
                dec_row = open_reg;
                dec_hit = 1'b1;
            end
            else
            begin
                dec_idx = d_idx_reg;
                dec_row = d_row_reg;
            end
        end
        else if (lkv_reg && a_reg)
        begin
            have    = 1'b1;
            dec_idx = a_idx_reg;
            dec_row = lkr_reg;
            dec_hit = 1'b1;
        end
        else if (b_reg)
        begin
            have    = 1'b1;
            dec_idx = b_idx_reg;
            dec_row = open_reg;
            dec_hit = 1'b1;
        end
        else
        begin
            have = c_reg;
        end
    end

    // Sequencer: next state and RAM port control
    always_comb
    begin
        state_next = state_reg;
        busy       = state_reg != frfcfs_pkg::S_IDLE;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_raddr  = {sel_reg, rd_cnt_reg[IW-1:0]};
        mem_waddr  = {to_wr, add_cnt[IW-1:0]};
        mem_wdata  = {bank, is_fill, write_req, tag, row};
        scan_end   = 1'b0;
        sweep_end  = 1'b0;
        case (state_reg)
            frfcfs_pkg::S_IDLE:
            begin
                if (accept && mode == frfcfs_pkg::MODE_ADD && !full)
                    mem_we = 1'b1;
                if (accept && bank_ok &&
                    (mode inside {frfcfs_pkg::MODE_SCHED, frfcfs_pkg::MODE_FILL}))
                    state_next = frfcfs_pkg::S_SCAN;
            end
            frfcfs_pkg::S_SCAN:
            begin
                mem_re = rd_cnt_reg < n_reg;
                if (rd_cnt_reg == n_reg && !rvalid_reg)
                begin
                    scan_end   = 1'b1;
                    state_next = have ? frfcfs_pkg::S_SWEEP : frfcfs_pkg::S_IDLE;
                end
            end
            frfcfs_pkg::S_SWEEP:
            begin
                mem_re    = rd_cnt_reg < n_reg;
                mem_we    = rvalid_reg && (ridx_reg > gidx_reg);
                mem_waddr = {sel_reg, IW'(ridx_reg - 1'b1)};
                mem_wdata = rdata_reg;
                if (rd_cnt_reg == n_reg && !rvalid_reg)
                begin
                    sweep_end  = 1'b1;
                    state_next = frfcfs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = frfcfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= frfcfs_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Pool RAM: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
            ridx_reg   <= '0;
        end
        else
        begin
            rvalid_reg <= mem_re;
            ridx_reg   <= rd_cnt_reg[IW-1:0];
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_reg <= 1'b0;
            high_reg  <= frfcfs_pkg::HIGH_RST;
            low_reg   <= frfcfs_pkg::LOW_RST;
            rlim_reg  <= frfcfs_pkg::LIMIT_RST;
            wlim_reg  <= frfcfs_pkg::LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                frfcfs_pkg::CFG_SPLIT:    split_reg <= cfg_data[0];
                frfcfs_pkg::CFG_HIGH:     high_reg  <= cfg_data;
                frfcfs_pkg::CFG_LOW:      low_reg   <= cfg_data;
                frfcfs_pkg::CFG_RD_LIMIT: rlim_reg  <= cfg_data;
                frfcfs_pkg::CFG_WR_LIMIT: wlim_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Counts, drain mode, locks, item context and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg     <= '0;
            wp_reg     <= '0;
            drain_reg  <= 1'b0;
            rd_cnt_reg <= '0;
            done_reg   <= 1'b0;
            status_reg <= frfcfs_pkg::STAT_NONE;
            for (int b = 0; b < LK_N; b++)
            begin
                lk_vld_reg[0][b] <= 1'b0;
                lk_vld_reg[1][b] <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (mem_re)
                rd_cnt_reg <= rd_cnt_reg + 1'b1;

            // Item entry
            if (accept)
            begin
                done_reg   <= 1'b1;
                status_reg <= frfcfs_pkg::STAT_NONE;
                otag_reg   <= '0;
                orow_reg   <= '0;
                owr_reg    <= 1'b0;
                ofill_reg  <= 1'b0;
                ohit_reg   <= 1'b0;
                case (mode)
                    frfcfs_pkg::MODE_ADD:
                    begin
                        status_reg <= full ? frfcfs_pkg::STAT_REFUSED
                                           : frfcfs_pkg::STAT_ADDED;
                        if (!full && to_wr)
                            wp_reg <= wp_reg + 1'b1;
                        else if (!full)
                            rp_reg <= rp_reg + 1'b1;
                    end
                    frfcfs_pkg::MODE_SCHED, frfcfs_pkg::MODE_FILL:
                    begin
                        if (bank_ok)
                        begin
                            done_reg   <= 1'b0;
                            drain_reg  <= drain_upd;
                            sel_reg    <= drain_upd;
                            bank_reg   <= bank;
                            open_reg   <= row;
                            fonly_reg  <= mode == frfcfs_pkg::MODE_FILL;
                            lkv_reg    <= lk_vld_reg[drain_upd][lk_in];
                            lkr_reg    <= lk_row_reg[drain_upd][lk_in];
                            n_reg      <= drain_upd ? wp_reg : rp_reg;
                            rd_cnt_reg <= '0;
                            a_reg      <= 1'b0;
                            b_reg      <= 1'b0;
                            c_reg      <= 1'b0;
                            d_reg      <= 1'b0;
                            e_reg      <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Scan: first entry of each candidate kind
            if (state_reg == frfcfs_pkg::S_SCAN && rvalid_reg && e_bm)
            begin
                if (!a_reg && e_row == lkr_reg)
                begin
                    a_reg     <= 1'b1;
                    a_idx_reg <= ridx_reg;
                end
                if (!b_reg && e_row == open_reg)
                begin
                    b_reg     <= 1'b1;
                    b_idx_reg <= ridx_reg;
                end
                if (!c_reg)
                begin
                    c_reg     <= 1'b1;
                    c_idx_reg <= ridx_reg;
                    c_row_reg <= e_row;
                end
                if (!d_reg && e_fill)
                begin
                    d_reg     <= 1'b1;
                    d_idx_reg <= ridx_reg;
                    d_row_reg <= e_row;
                end
                if (!e_reg && e_fill && e_row == open_reg)
                begin
                    e_reg     <= 1'b1;
                    e_idx_reg <= ridx_reg;
                end
            end

            // Scan done: commit choice or report nothing
            if (scan_end)
            begin
                if (have)
                begin
                    gidx_reg   <= dec_idx;
                    grow_reg   <= dec_row;
                    hit_reg    <= dec_hit;
                    still_reg  <= 1'b0;
                    rd_cnt_reg <= '0;
                end
                else
                begin
                    done_reg <= 1'b1;
                    if (!fonly_reg)
                        lk_vld_reg[sel_reg][lk_cur] <= 1'b0;
                end
            end

            // Sweep: take the grant, compact, look for more of its row
            if (state_reg == frfcfs_pkg::S_SWEEP && rvalid_reg)
            begin
                if (ridx_reg == gidx_reg)
                begin
                    gtag_reg  <= rdata_reg[ROW_BITS +: TAG_BITS];
                    gwr_reg   <= rdata_reg[WR_B];
                    gfill_reg <= e_fill;
                end
                else if (e_bm && e_row == grow_reg)
                begin
                    still_reg <= 1'b1;
                end
            end

            if (sweep_end)
            begin
                if (sel_reg)
                    wp_reg <= wp_reg - 1'b1;
                else
                    rp_reg <= rp_reg - 1'b1;
                lk_vld_reg[sel_reg][lk_cur] <= still_reg;
                lk_row_reg[sel_reg][lk_cur] <= grow_reg;
                done_reg   <= 1'b1;
                status_reg <= frfcfs_pkg::STAT_GRANTED;
                otag_reg   <= gtag_reg;
                orow_reg   <= grow_reg;
                owr_reg    <= gwr_reg;
                ofill_reg  <= gfill_reg;
                ohit_reg   <= hit_reg;
            end
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_tag   = otag_reg;
    assign granted_row   = orow_reg;
    assign granted_write = owr_reg;
    assign granted_fill  = ofill_reg;
    assign row_hit       = ohit_reg;

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while a schedule is still running");

    a_pend_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(rp_reg) <= POOL_CAP) && (CW'(wp_reg) <= POOL_CAP))
        else $error("pending count beyond pool size");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != frfcfs_pkg::STAT_GRANTED) |->
        (granted_tag == '0 && granted_row == '0 && !row_hit))
        else $error("grant fields set without a grant");

    a_drain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(drain_reg))
        else $error("drain mode changed outside a schedule item");

endmodule
